// ===== sv/pcos_pkg.sv =====
`timescale 1ns / 1ps
package pcos_pkg;

	localparam logic [15:0] POSIT_NAR  = 16'h8000;
	localparam logic [15:0] POSIT_ONE  = 16'h4000;
	localparam logic [15:0] POSIT_MONE = 16'hC000;
	localparam logic [15:0] POSIT_ZERO = 16'h0000;

	localparam logic [27:0] HALF_UNIT = 28'h8000000;
	localparam logic [26:0] FLAT_LIM  = 27'h00E6001;
	localparam logic [24:0] FLAT_MAG  = 25'h1FFFFFF;

	localparam logic [14:0] K_C4 = 15'd28875;
	localparam logic [18:0] K_C3 = 19'd349194;
	localparam logic [22:0] K_C2 = 23'd4255560;
	localparam logic [24:0] K_C1 = 25'd20698014;
	localparam logic [25:0] K_C0 = 26'd33554428;

	typedef struct packed {
		logic              nar;
		logic signed [6:0] sc;
		logic [12:0]       mant;
	} dec_t;

	typedef struct packed {
		logic        spec;
		logic [15:0] val;
		logic        neg;
	} tag_t;

	function automatic logic [3:0] lzc14(input logic [13:0] y);
		logic [3:0] cnt;
		cnt = 4'd14;
		for (int i = 0; i < 14; i++) begin
			if (y[i]) begin
				cnt = 4'(13 - i);
			end
		end
		return cnt;
	endfunction

	function automatic logic [4:0] lzc25(input logic [24:0] y);
		logic [4:0] cnt;
		cnt = 5'd25;
		for (int i = 0; i < 25; i++) begin
			if (y[i]) begin
				cnt = 5'(24 - i);
			end
		end
		return cnt;
	endfunction

endpackage

// ===== sv/pcos_dec.sv =====
`timescale 1ns / 1ps
module pcos_dec (
	input  logic [15:0]   posit,
	output pcos_pkg::dec_t dec
);
	import pcos_pkg::*;

	logic [15:0] a;
	logic        ones;
	logic [13:0] y;
	logic [3:0]  k;
	logic [13:0] w;
	int          sc_int;

	always_comb begin
		a      = posit[15] ? (~posit + 16'd1) : posit;
		ones   = a[14];
		y      = ones ? ~a[13:0] : a[13:0];
		k      = lzc14(y);
		w      = a[13:0] << k;
		if (ones) begin
			sc_int = 16 + 2 * int'(k) + int'(w[12]);
		end else begin
			sc_int = 14 - 2 * int'(k) + int'(w[12]);
		end
		dec.nar  = (posit == POSIT_NAR);
		dec.sc   = 7'(sc_int);
		dec.mant = {1'b1, w[11:0]};
	end

endmodule

// ===== sv/pcos_enc.sv =====
`timescale 1ns / 1ps
module pcos_enc (
	input  logic [24:0] mn,
	input  logic [4:0]  n,
	input  logic        neg,
	output logic [15:0] posit
);
	import pcos_pkg::*;

	logic        e_even;
	logic [4:0]  e;
	logic [4:0]  sh;
	logic [25:0] m2;
	logic [25:0] shifted;
	logic [25:0] low_mask;
	logic        guard;
	logic        sticky;
	logic [15:0] mag;

	always_comb begin
		e_even   = n[0];
		e        = n + 5'd1;
		sh       = 5'((e >> 1) + 5'd12 - {4'd0, e_even});
		m2       = {1'b1, (e_even ? {1'b0, mn[23:0]} : mn)};
		shifted  = m2 >> sh;
		guard    = m2[sh - 5'd1];
		low_mask = (26'd1 << (sh - 5'd1)) - 26'd1;
		sticky   = |(m2 & low_mask);
		mag      = shifted[15:0] + {15'd0, guard & (sticky | shifted[0])};
		posit    = neg ? (~mag + 16'd1) : mag;
	end

endmodule

// ===== sv/posit16_cos_pi_top.sv =====
`timescale 1ns / 1ps
// posit16_cos_pi_top: cos(pi*x) for 16-bit posits with es = 1
// arg channel: arg_valid / arg_ready carry posit_in (raw posit pattern, 0x8000 is NaR)
// res channel: res_valid / res_ready carry posit_out (raw posit pattern of the cosine)
// one result per argument, in order; NaR comes back unchanged
// path: the argument is registered into stage 1 and moves on stage by stage to stage 9,
// whose valid bit is res_valid
// throughput: one argument per cycle while results are taken, set by the nine-stage pipeline
// (decode, range split, square, four Horner multiply stages, normalize, round)
// every stage holds a valid bit; a stage loads whenever it is empty or moves on,
// so bubbles are squeezed out while the receiver holds res_ready low
// arg_ready drops only when all nine stages are full and the result is not taken
// the last stage is the output register, so posit_out holds steady while stalled
// reset empties the pipeline: res_valid low and arg_ready high while in reset
module posit16_cos_pi_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        arg_valid,
	output logic        arg_ready,
	input  logic [15:0] posit_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] posit_out
);
	import pcos_pkg::*;

	logic [9:1] vld;
	logic [9:1] en;

	dec_t        dec_c;
	dec_t        dec_s1;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	tag_t        tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [26:0] r_s2;
	logic [23:0] t_s3, t_s4, t_s5, t_s6;
	logic        flat_s3, flat_s4, flat_s5, flat_s6;
	logic [18:0] acc_s4;
	logic [22:0] acc_s5;
	logic [24:0] acc_s6;
	logic [24:0] m_s7;
	logic [24:0] mn_s8;
	logic [4:0]  n_s8;
	logic [15:0] posit_s9;

	// stage 2 logic
	logic [28:0] ext;
	logic [28:0] v;
	logic [1:0]  q;
	logic [26:0] r;
	tag_t        tag_c2;
	logic [27:0] refl;

	// later stage logic
	logic [15:0] u;
	logic [31:0] sq;
	logic [38:0] p4;
	logic [42:0] p5;
	logic [46:0] p6;
	logic [48:0] p7;
	logic [25:0] m26;
	logic [24:0] m_c7;
	tag_t        tag_c7;
	logic [4:0]  n_c8;
	logic [15:0] enc_posit;

	assign vld = {vld_s9, vld_s8, vld_s7, vld_s6, vld_s5, vld_s4, vld_s3, vld_s2, vld_s1};

	always_comb begin
		en[9] = !vld[9] || res_ready;
		for (int i = 8; i >= 1; i--) begin
			en[i] = !vld[i] || en[i + 1];
		end
	end

	assign arg_ready = en[1];
	assign res_valid = vld_s9;
	assign posit_out = posit_s9;

	pcos_dec u_dec (
		.posit(posit_in),
		.dec  (dec_c)
	);

	// range split and reflection
	always_comb begin
		ext = 29'(dec_s1.mant);
		if (dec_s1.sc < 0) begin
			v = ext >> 6'(-dec_s1.sc);
		end else begin
			v = ext << 6'(dec_s1.sc);
		end
		q          = v[28:27];
		r          = v[26:0];
		refl       = HALF_UNIT - {1'b0, r};
		tag_c2.neg = (q == 2'd1) || (q == 2'd2);
		tag_c2.spec = 1'b0;
		tag_c2.val  = POSIT_ZERO;
		if (dec_s1.nar) begin
			tag_c2.spec = 1'b1;
			tag_c2.val  = POSIT_NAR;
		end else if (r == 27'd0) begin
			tag_c2.spec = 1'b1;
			if (q[0]) begin
				tag_c2.val = POSIT_ZERO;
			end else if (tag_c2.neg) begin
				tag_c2.val = POSIT_MONE;
			end else begin
				tag_c2.val = POSIT_ONE;
			end
		end
	end

	// square, horner chain, flat clamp and leading-zero count
	always_comb begin
		u   = r_s2[26:11];
		sq  = 32'(u) * 32'(u);
		p4  = 39'(t_s3) * 39'(K_C4);
		p5  = 43'(t_s4) * 43'(acc_s4);
		p6  = 47'(t_s5) * 47'(acc_s5);
		p7  = 49'(t_s6) * 49'(acc_s6);
		m26 = K_C0 - 26'(p7 >> 23);
		m_c7   = flat_s6 ? FLAT_MAG : m26[24:0];
		tag_c7 = tag_s6;
		if (!tag_s6.spec && (m_c7 == 25'd0)) begin
			tag_c7.spec = 1'b1;
			tag_c7.val  = POSIT_ZERO;
		end
		n_c8 = lzc25(m_s7);
	end

	pcos_enc u_enc (
		.mn   (mn_s8),
		.n    (n_s8),
		.neg  (tag_s8.neg),
		.posit(enc_posit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en[1]) vld_s1 <= arg_valid;
			if (en[2]) vld_s2 <= vld_s1;
			if (en[3]) vld_s3 <= vld_s2;
			if (en[4]) vld_s4 <= vld_s3;
			if (en[5]) vld_s5 <= vld_s4;
			if (en[6]) vld_s6 <= vld_s5;
			if (en[7]) vld_s7 <= vld_s6;
			if (en[8]) vld_s8 <= vld_s7;
			if (en[9]) vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dec_s1 <= dec_c;
		end
		if (en[2]) begin
			tag_s2 <= tag_c2;
			r_s2   <= q[0] ? refl[26:0] : r;
		end
		if (en[3]) begin
			tag_s3  <= tag_s2;
			flat_s3 <= (r_s2 < FLAT_LIM);
			t_s3    <= sq[31:8];
		end
		if (en[4]) begin
			tag_s4  <= tag_s3;
			flat_s4 <= flat_s3;
			t_s4    <= t_s3;
			acc_s4  <= K_C3 - 19'(p4 >> 25);
		end
		if (en[5]) begin
			tag_s5  <= tag_s4;
			flat_s5 <= flat_s4;
			t_s5    <= t_s4;
			acc_s5  <= K_C2 - 23'(p5 >> 24);
		end
		if (en[6]) begin
			tag_s6  <= tag_s5;
			flat_s6 <= flat_s5;
			t_s6    <= t_s5;
			acc_s6  <= K_C1 - 25'(p6 >> 24);
		end
		if (en[7]) begin
			tag_s7 <= tag_c7;
			m_s7   <= m_c7;
		end
		if (en[8]) begin
			tag_s8 <= tag_s7;
			n_s8   <= n_c8;
			mn_s8  <= m_s7 << n_c8;
		end
		if (en[9]) begin
			posit_s9 <= tag_s8.spec ? tag_s8.val : enc_posit;
		end
	end

endmodule

// ===== sv/pcos_chk.sv =====
`timescale 1ns / 1ps
module pcos_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        arg_valid,
	input logic        arg_ready,
	input logic [15:0] posit_in,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] posit_out
);
	import pcos_pkg::*;

	// waiting argument stays put
	a_arg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && !arg_ready |=> arg_valid && $stable(posit_in))
		else $error("argument changed while waiting");

	// stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(posit_out))
		else $error("result changed while stalled");

	// input side only blocks when the output is stalled
	a_block_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!arg_ready |-> res_valid && !res_ready)
		else $error("arg_ready low without output stall");

	// a result transfer frees room for a new argument
	a_free_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> arg_ready)
		else $error("arg_ready low during result transfer");

	// cosine lies in [-1, 1] or is NaR
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (posit_out <= POSIT_ONE) || (posit_out >= POSIT_MONE) ||
			(posit_out == POSIT_NAR))
		else $error("result outside [-1, 1]");

endmodule

bind posit16_cos_pi_top pcos_chk u_pcos_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.arg_valid(arg_valid),
	.arg_ready(arg_ready),
	.posit_in (posit_in),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.posit_out(posit_out)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam logic [15:0] ARG_NAR    = 16'h8000;
	localparam logic [15:0] COS_ONE    = 16'h4000;
	localparam logic [15:0] COS_MONE   = 16'hC000;
	localparam logic [15:0] COS_ZERO   = 16'h0000;

	localparam int RX_ALWAYS = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_MOSTLY = 2;
	localparam int RX_PERIOD = 3;

	localparam int N_CORNER = 24;
	localparam logic [15:0] CORNER_ARGS [N_CORNER] = '{
		16'h0000, 16'h8000, 16'h4000, 16'hC000, 16'h3000, 16'hD000,
		16'h4800, 16'h5000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8001,
		16'h2000, 16'h2800, 16'h3800, 16'h4400, 16'h6000, 16'h7000,
		16'h1000, 16'h0100, 16'h3FFF, 16'h4001, 16'hBFFF, 16'h5555
	};

	typedef struct {
		logic [15:0] arg;
		logic [15:0] cosine;
	} cos_entry_t;

	class cos_pi_scoreboard;
		cos_entry_t waiting[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// |x| as fixed point with 28 fraction bits
		function longint unsigned mag_to_fixed(input logic [15:0] a);
			longint unsigned v;
			int scale;
			v = a;
			if (v[14]) begin
				scale = 16;
				for (int i = 0; i < 15 && v[13]; i++) begin
					v = v << 1;
					scale += 2;
				end
			end else begin
				scale = 14;
				for (int i = 0; i < 15 && !v[13]; i++) begin
					v = v << 1;
					scale -= 2;
				end
			end
			if (v[12])
				scale += 1;
			v = (v & 64'h0FFF) | 64'h1000;
			if (scale < 0)
				return v >> (-scale);
			return v << scale;
		endfunction

		// cos(pi*r) scaled by 2^25, r in units of 2^-28
		function longint unsigned cos_mag(input longint unsigned r);
			longint unsigned t;
			longint unsigned acc;
			if (r < 64'h000E_6001)
				return 64'h01FF_FFFF;
			t = r >> 11;
			t = (t * t) >> 8;
			acc = 64'd349194 - ((t * 64'd28875) >> 25);
			acc = 64'd4255560 - ((t * acc) >> 24);
			acc = 64'd20698014 - ((t * acc) >> 24);
			return (64'd33554428 - ((t * acc) >> 23)) & 64'h03FF_FFFF;
		endfunction

		// normalize and round to nearest even into a positive posit
		function logic [15:0] mag_to_posit(input longint unsigned m);
			int e;
			int unsigned sh;
			longint unsigned rb;
			e = 1;
			for (int i = 0; i < 26 && !m[24]; i++) begin
				m = m << 1;
				e++;
			end
			if (e % 2 == 0)
				m = m & 64'h00FF_FFFF;
			sh = (e >> 1) + 12 - ((e % 2 == 0) ? 1 : 0);
			m = m | 64'h0200_0000;
			rb = 64'd1 << (sh - 1);
			if ((m & rb) != 0 && ((m & (rb - 1)) != 0 || (m & (rb << 1)) != 0))
				m = m + rb;
			return 16'(m >> sh);
		endfunction

		function logic [15:0] cos_pi_expect(input logic [15:0] x);
			logic [15:0] a;
			logic [15:0] res;
			longint unsigned v;
			longint unsigned r;
			longint unsigned m;
			logic [1:0] quad;
			logic neg;
			if (x == ARG_NAR)
				return x;
			a = x[15] ? 16'(-x) : x;
			v = (a != 0) ? mag_to_fixed(a) : 64'd0;
			quad = v[28:27];
			r = v & 64'h07FF_FFFF;
			neg = (quad == 2'd1) || (quad == 2'd2);
			if (r == 0) begin
				if (quad[0])
					return COS_ZERO;
				return neg ? COS_MONE : COS_ONE;
			end
			if (quad[0])
				r = 64'h0800_0000 - r;
			m = cos_mag(r);
			if (m == 0)
				return COS_ZERO;
			res = mag_to_posit(m);
			if (neg)
				res = -res;
			return res;
		endfunction

		function void note_arg(input logic [15:0] x);
			cos_entry_t ent;
			ent.arg = x;
			ent.cosine = cos_pi_expect(x);
			waiting.push_back(ent);
		endfunction

		function void check_result(input logic [15:0] y);
			cos_entry_t ent;
			if (waiting.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer: expected none, got %h", $time, y);
				return;
			end
			ent = waiting.pop_front();
			if (y !== ent.cosine) begin
				errors++;
				$display("%0t: posit_out for posit_in %h: expected %h, got %h",
					$time, ent.arg, ent.cosine, y);
			end
		endfunction

		function int pending();
			return waiting.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        arg_valid = 1'b0;
	logic        arg_ready;
	logic [15:0] posit_in  = 16'h0000;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [15:0] posit_out;

	cos_pi_scoreboard board;
	int rx_mode  = RX_ALWAYS;
	bit hold_req = 1'b0;

	posit16_cos_pi_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (arg_valid),
		.arg_ready (arg_ready),
		.posit_in  (posit_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.posit_out (posit_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [15:0] pick_arg();
		int sel;
		logic [15:0] mag;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 16'($urandom_range(0, 65535));
		if (sel < 88) begin
			// magnitudes around the interesting quadrants
			mag = 16'($urandom_range(16'h0400, 16'h5C00));
			return $urandom_range(0, 1) ? 16'(-mag) : mag;
		end
		return CORNER_ARGS[$urandom_range(0, N_CORNER - 1)];
	endfunction

	task automatic send_arg(input logic [15:0] x);
		arg_valid <= 1'b1;
		posit_in  <= x;
		do @(posedge clk); while (!arg_ready);
		board.note_arg(x);
	endtask

	task automatic send_phase(input int n, input int max_gap);
		int burst;
		int gap;
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && n > 0; k++) begin
				send_arg(pick_arg());
				n--;
			end
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap != 0) begin
				arg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// result side
	initial begin
		int hold_cnt;
		int rx_cycle;
		hold_cnt = 0;
		rx_cycle = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (res_valid && res_ready)
				board.check_result(posit_out);
			if (!arst_n) begin
				res_ready <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt--;
				res_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 60;
				res_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: res_ready <= 1'b1;
					RX_COIN:   res_ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: res_ready <= ($urandom_range(0, 3) != 0);
					RX_PERIOD: res_ready <= (rx_cycle % 5 != 2) && (rx_cycle % 11 > 3);
					default:   res_ready <= 1'b1;
				endcase
			end
		end
	end

	// argument side
	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (CORNER_ARGS[i])
			send_arg(CORNER_ARGS[i]);
		arg_valid <= 1'b0;
		drain();

		for (int p = 0; p < 6; p++) begin
			rx_mode = p % 4;
			if (p == 2) begin
				// receiver holds off long enough to back up the pipeline
				hold_req = 1'b1;
				send_phase(40, 0);
			end
			send_phase(100, (p == 0) ? 0 : (p % 3) * 3 + 1);
			arg_valid <= 1'b0;
			drain();
		end

		rx_mode = RX_ALWAYS;
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== posit16_cos_pi_top.f =====
sv/pcos_pkg.sv
sv/pcos_dec.sv
sv/pcos_enc.sv
sv/posit16_cos_pi_top.sv
sv/pcos_chk.sv
bench/tb.sv
